FILE: rtl/led_fade_channel_engine_macros.svh
// Assertion macros shared by the checker of the LED fade channel engine.
`ifndef LED_FADE_CHANNEL_ENGINE_MACROS_SVH
`define LED_FADE_CHANNEL_ENGINE_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define LFE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define LFE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lfe_pkg.sv
// Shared types and constants of the LED fade channel engine.
package lfe_pkg;

   localparam int NUM_CHANNELS_DEFAULT = 5;
   localparam int RESULT_CAP = 5;
   localparam int EMIT_CNT_W = 3;

   localparam logic [2:0] KIND_TICK  = 3'd0;
   localparam logic [2:0] KIND_SET   = 3'd1;
   localparam logic [2:0] KIND_RESET = 3'd2;
   localparam logic [2:0] KIND_STOP  = 3'd3;
   localparam logic [2:0] KIND_CLEAR = 3'd4;

   localparam logic [7:0] LIMIT_ENDLESS = 8'hFF;

   typedef struct packed {
      logic accept_tick;
      logic accept_cmd;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic work_left;
      logic load_last;
   } status_type;

endpackage

FILE: rtl/led_fade_channel_engine.sv
// Top level of the LED fade channel engine.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  kind, channel, start_level, step, lower,
//                                              upper, loop_limit
//   rsp      out        rsp_valid / rsp_ready  out_channel, level, matched, last
//
// A tick updates all channels in the cycle it is accepted, then the output slot
// emits one item per cycle, unless the slot is stalled, from the lowest pending channel:
// up to five items, so a tick holds the input until its last item is loaded; a tick
// where nothing moved gives no item; a command gives one item; an unused kind gives none.
// Reset loads every channel to level 0, step 1, bounds, limit and count 0.
// A stalled output slot holds its item; the next input is taken while the last item
// of the previous one waits.
module led_fade_channel_engine #(
   parameter int NUM_CHANNELS = lfe_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_kind,
   input  logic [2:0]        req_channel,
   input  logic [7:0]        req_start_level,
   input  logic signed [7:0] req_step,
   input  logic [7:0]        req_lower,
   input  logic [7:0]        req_upper,
   input  logic signed [7:0] req_loop_limit,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_out_channel,
   output logic [7:0]        rsp_level,
   output logic              rsp_matched,
   output logic              rsp_last
);

   lfe_pkg::cmd_type    cmd;
   lfe_pkg::status_type status;

   lfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lfe_datapath #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_kind),
      .req_channel     (req_channel),
      .req_start_level (req_start_level),
      .req_step        (req_step),
      .req_lower       (req_lower),
      .req_upper       (req_upper),
      .req_loop_limit  (req_loop_limit),
      .rsp_out_channel (rsp_out_channel),
      .rsp_level       (rsp_level),
      .rsp_matched     (rsp_matched),
      .rsp_last        (rsp_last)
   );

endmodule

FILE: rtl/lfe_ctrl.sv
// Controller of the LED fade channel engine: input handshake, sequencing, result valid.
module lfe_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_kind,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  lfe_pkg::status_type status,
   output lfe_pkg::cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.accept_tick = accept && (req_kind == lfe_pkg::KIND_TICK);
      cmd.accept_cmd  = accept && (req_kind inside {lfe_pkg::KIND_SET, lfe_pkg::KIND_RESET,
                                                    lfe_pkg::KIND_STOP, lfe_pkg::KIND_CLEAR});
      cmd.load        = (state_ff == ST_EMIT) && status.work_left && slot_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept_tick || cmd.accept_cmd) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // leave once the final item of this input is in the output slot, or when none is left
            if (!status.work_left || (cmd.load && status.load_last)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/lfe_datapath.sv
// Datapath of the LED fade channel engine: channel state, tick update, command apply, output slot.
module lfe_datapath #(
   parameter int NUM_CHANNELS = lfe_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  lfe_pkg::cmd_type    cmd,
   output lfe_pkg::status_type status,
   input  logic [2:0]          req_kind,
   input  logic [2:0]          req_channel,
   input  logic [7:0]          req_start_level,
   input  logic signed [7:0]   req_step,
   input  logic [7:0]          req_lower,
   input  logic [7:0]          req_upper,
   input  logic signed [7:0]   req_loop_limit,
   output logic [2:0]          rsp_out_channel,
   output logic [7:0]          rsp_level,
   output logic                rsp_matched,
   output logic                rsp_last
);

   logic [7:0] level_ff [NUM_CHANNELS];
   logic [7:0] step_ff  [NUM_CHANNELS];
   logic [7:0] low_ff   [NUM_CHANNELS];
   logic [7:0] high_ff  [NUM_CHANNELS];
   logic [7:0] limit_ff [NUM_CHANNELS];
   logic [7:0] count_ff [NUM_CHANNELS];
   logic [7:0] level_in [NUM_CHANNELS];
   logic [7:0] step_in  [NUM_CHANNELS];
   logic [7:0] low_in   [NUM_CHANNELS];
   logic [7:0] high_in  [NUM_CHANNELS];
   logic [7:0] limit_in [NUM_CHANNELS];
   logic [7:0] count_in [NUM_CHANNELS];

   logic [NUM_CHANNELS-1:0] tick_move;
   logic [NUM_CHANNELS-1:0] pend_ff, pend_in;
   logic [NUM_CHANNELS-1:0] pend_rest;
   logic                    cmd_pend_ff, cmd_pend_in;
   logic [2:0]              cmd_ch_ff;
   logic                    cmd_hit_ff;
   logic                    req_hit;
   logic [lfe_pkg::EMIT_CNT_W-1:0] emit_cnt_ff, emit_cnt_in;
   logic [2:0]              pick_idx;
   logic [7:0]              pick_level;
   logic [7:0]              cmd_level;
   logic                    tick_last;

   logic [2:0]  out_channel_ff, out_channel_in;
   logic [7:0]  out_level_ff, out_level_in;
   logic        out_matched_ff, out_matched_in;
   logic        out_last_ff, out_last_in;

   assign req_hit = int'(req_channel) < NUM_CHANNELS;

   // Tick update of every channel side by side, and command writes.
   always_comb begin
      logic signed [9:0] sum;
      logic signed [8:0] cnt_s;
      logic signed [8:0] lim_s;
      logic              active;
      logic [7:0]        new_cnt;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         level_in[i] = level_ff[i];
         step_in[i]  = step_ff[i];
         low_in[i]   = low_ff[i];
         high_in[i]  = high_ff[i];
         limit_in[i] = limit_ff[i];
         count_in[i] = count_ff[i];
         tick_move[i] = 1'b0;

         cnt_s  = $signed({1'b0, count_ff[i]});
         lim_s  = $signed({limit_ff[i][7], limit_ff[i]});
         active = (step_ff[i] != 8'd0)
                  && ((limit_ff[i] == lfe_pkg::LIMIT_ENDLESS) || (cnt_s < lim_s));
         sum    = $signed({2'b00, level_ff[i]})
                  + $signed({{2{step_ff[i][7]}}, step_ff[i]});
         tick_move[i] = active && (sum >= $signed({2'b00, low_ff[i]}))
                        && (sum <= $signed({2'b00, high_ff[i]}));
         new_cnt = tick_move[i] ? count_ff[i] + 8'd1 : count_ff[i];

         if (cmd.accept_tick) begin
            if (tick_move[i]) level_in[i] = sum[7:0];
            count_in[i] = new_cnt;
            // drop the step once the limit is used up
            if ((step_ff[i] != 8'd0) && (limit_ff[i] != lfe_pkg::LIMIT_ENDLESS)
                && ($signed({1'b0, new_cnt}) >= lim_s)) step_in[i] = 8'd0;
         end else if (cmd.accept_cmd && (req_channel == 3'(i))) begin
            case (req_kind)
               lfe_pkg::KIND_SET: begin
                  level_in[i] = req_start_level;
                  step_in[i]  = req_step;
                  low_in[i]   = req_lower;
                  high_in[i]  = req_upper;
                  limit_in[i] = req_loop_limit;
                  count_in[i] = 8'd0;
               end
               lfe_pkg::KIND_RESET: begin
                  level_in[i] = low_ff[i];
                  count_in[i] = 8'd0;
               end
               lfe_pkg::KIND_STOP: step_in[i] = 8'd0;
               lfe_pkg::KIND_CLEAR: begin
                  level_in[i] = 8'd0;
                  step_in[i]  = 8'd0;
                  low_in[i]   = 8'd0;
                  high_in[i]  = 8'd0;
                  limit_in[i] = 8'd0;
                  count_in[i] = 8'd0;
               end
               default: ;
            endcase
         end
      end
   end

   // Lowest pending channel and the levels the output slot needs.
   always_comb begin
      logic found;
      found      = 1'b0;
      pick_idx   = 3'd0;
      pick_level = 8'd0;
      cmd_level  = 8'd0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (!found && pend_ff[i]) begin
            found      = 1'b1;
            pick_idx   = 3'(i);
            pick_level = level_ff[i];
         end
         if (cmd_ch_ff == 3'(i)) cmd_level = level_ff[i];
      end
   end

   always_comb begin
      pend_rest = pend_ff;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (pick_idx == 3'(i)) pend_rest[i] = 1'b0;
      end
   end

   assign tick_last = (emit_cnt_ff == lfe_pkg::EMIT_CNT_W'(lfe_pkg::RESULT_CAP - 1))
                      || (pend_rest == '0);

   always_comb begin
      pend_in        = pend_ff;
      cmd_pend_in    = cmd_pend_ff;
      emit_cnt_in    = emit_cnt_ff;
      out_channel_in = out_channel_ff;
      out_level_in   = out_level_ff;
      out_matched_in = out_matched_ff;
      out_last_in    = out_last_ff;
      if (cmd.accept_tick) begin
         pend_in     = tick_move;
         emit_cnt_in = '0;
      end else if (cmd.accept_cmd) begin
         cmd_pend_in = 1'b1;
      end else if (cmd.load) begin
         if (cmd_pend_ff) begin
            cmd_pend_in    = 1'b0;
            out_channel_in = cmd_ch_ff;
            out_level_in   = cmd_hit_ff ? cmd_level : 8'd0;
            out_matched_in = cmd_hit_ff;
            out_last_in    = 1'b1;
         end else begin
            // past the result cap the rest of the tick is dropped
            pend_in        = tick_last ? '0 : pend_rest;
            emit_cnt_in    = emit_cnt_ff + lfe_pkg::EMIT_CNT_W'(1);
            out_channel_in = pick_idx;
            out_level_in   = pick_level;
            out_matched_in = 1'b1;
            out_last_in    = tick_last;
         end
      end
   end

   always_comb begin
      status.work_left = cmd_pend_ff || (pend_ff != '0);
      status.load_last = cmd_pend_ff || tick_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            level_ff[i] <= 8'd0;
            step_ff[i]  <= 8'd1;
            low_ff[i]   <= 8'd0;
            high_ff[i]  <= 8'd0;
            limit_ff[i] <= 8'd0;
            count_ff[i] <= 8'd0;
         end
         pend_ff     <= '0;
         cmd_pend_ff <= 1'b0;
         emit_cnt_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            level_ff[i] <= level_in[i];
            step_ff[i]  <= step_in[i];
            low_ff[i]   <= low_in[i];
            high_ff[i]  <= high_in[i];
            limit_ff[i] <= limit_in[i];
            count_ff[i] <= count_in[i];
         end
         pend_ff     <= pend_in;
         cmd_pend_ff <= cmd_pend_in;
         emit_cnt_ff <= emit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_cmd) begin
         cmd_ch_ff  <= req_channel;
         cmd_hit_ff <= req_hit;
      end
      out_channel_ff <= out_channel_in;
      out_level_ff   <= out_level_in;
      out_matched_ff <= out_matched_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_out_channel = out_channel_ff;
   assign rsp_level       = out_level_ff;
   assign rsp_matched     = out_matched_ff;
   assign rsp_last        = out_last_ff;

endmodule

FILE: rtl/lfe_checker.sv
// Port-level checker of the LED fade channel engine, bound to the top level.
`include "led_fade_channel_engine_macros.svh"

module lfe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_out_channel,
   input logic [7:0] rsp_level,
   input logic       rsp_matched,
   input logic       rsp_last
);

   // a stalled item stays put
   `LFE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_level) && $stable(rsp_out_channel), "rsp item changed while stalled")

   // the next item of a tick follows right after a non-final one is taken
   `LFE_ASSERT_NEXT(a_tick_burst, rsp_valid && rsp_ready && !rsp_last, rsp_valid, "gap inside a tick burst")

   // an unmatched command reports level zero as its only item
   `LFE_ASSERT_NOW(a_miss_item, rsp_valid && !rsp_matched, rsp_level == 8'd0 && rsp_last, "bad unmatched item")

   // no new input while a tick still has items to send
   `LFE_ASSERT_NOW(a_busy_burst, rsp_valid && !rsp_last, !req_ready, "input taken mid burst")

endmodule

bind led_fade_channel_engine lfe_checker u_lfe_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_channel (rsp_out_channel),
   .rsp_level       (rsp_level),
   .rsp_matched     (rsp_matched),
   .rsp_last        (rsp_last)
);

FILE: tb/sv/led_fade_channel_engine_tb.sv
// Self-checking testbench for the LED fade channel engine: directed table, then random items.
module led_fade_channel_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CH        = lfe_pkg::NUM_CHANNELS_DEFAULT;
   localparam int RESULT_CAP    = lfe_pkg::RESULT_CAP;
   localparam int RANDOM_ITEMS  = 275;
   localparam int PAUSE_AT      = 150;
   localparam int HOLD_AT       = 60;
   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 20;

   localparam logic [2:0] KIND_TICK     = lfe_pkg::KIND_TICK;
   localparam logic [2:0] KIND_SET      = lfe_pkg::KIND_SET;
   localparam logic [2:0] KIND_RESET    = lfe_pkg::KIND_RESET;
   localparam logic [2:0] KIND_STOP     = lfe_pkg::KIND_STOP;
   localparam logic [2:0] KIND_CLEAR    = lfe_pkg::KIND_CLEAR;
   localparam logic [7:0] LIMIT_ENDLESS = lfe_pkg::LIMIT_ENDLESS;

   // Kind codes the block ignores.
   localparam logic [2:0] KIND_SPARE_LO = 3'd5;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   typedef struct {
      logic [2:0]        kind;
      logic [2:0]        channel;
      logic [7:0]        start_level;
      logic signed [7:0] step;
      logic [7:0]        lower;
      logic [7:0]        upper;
      logic signed [7:0] loop_limit;
      bit                typed;
      logic [7:0]        typed_level;
      logic              typed_matched;
   } fade_item_type;

   typedef struct {
      logic [2:0] out_channel;
      logic [7:0] level;
      logic       matched;
      logic       last;
   } fade_result_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [2:0]        rsp_out_channel;
   logic [7:0]        rsp_level;
   logic              rsp_matched;
   logic              rsp_last;
   fade_item_type     offered;

   // Channel state of the predictor.
   logic [7:0]        ch_level [NUM_CH];
   logic signed [7:0] ch_step  [NUM_CH];
   logic [7:0]        ch_lower [NUM_CH];
   logic [7:0]        ch_upper [NUM_CH];
   logic signed [7:0] ch_limit [NUM_CH];
   logic [7:0]        ch_count [NUM_CH];

   fade_result_type   levels_due [$];
   fade_item_type     directed_items [$];
   int                fail_count = 0;
   int                idle_cycles = 0;
   int                items_offered = 0;

   led_fade_channel_engine DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (offered.kind),
      .req_channel     (offered.channel),
      .req_start_level (offered.start_level),
      .req_step        (offered.step),
      .req_lower       (offered.lower),
      .req_upper       (offered.upper),
      .req_loop_limit  (offered.loop_limit),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_channel (rsp_out_channel),
      .rsp_level       (rsp_level),
      .rsp_matched     (rsp_matched),
      .rsp_last        (rsp_last)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic fade_item_type fade_item(logic [2:0] kind, logic [2:0] channel,
                                               logic [7:0] start_level,
                                               logic signed [7:0] step,
                                               logic [7:0] lower, logic [7:0] upper,
                                               logic signed [7:0] loop_limit, bit typed,
                                               logic [7:0] typed_level,
                                               logic typed_matched);
      fade_item_type it;
      it.kind          = kind;
      it.channel       = channel;
      it.start_level   = start_level;
      it.step          = step;
      it.lower         = lower;
      it.upper         = upper;
      it.loop_limit    = loop_limit;
      it.typed         = typed;
      it.typed_level   = typed_level;
      it.typed_matched = typed_matched;
      return it;
   endfunction

   // Advance one channel by its step; return 1 when the level moved.
   function automatic bit fade_channel_moves(int i);
      bit moved;
      int sum;
      moved = 1'b0;
      if (ch_step[i] == 8'sd0)
         return 1'b0;
      if (ch_limit[i] == LIMIT_ENDLESS || int'(ch_count[i]) < int'(ch_limit[i])) begin
         sum = int'(ch_level[i]) + int'(ch_step[i]);
         if (sum >= int'(ch_lower[i]) && sum <= int'(ch_upper[i])) begin
            ch_level[i] = 8'(sum);
            ch_count[i] = ch_count[i] + 8'd1;
            moved = 1'b1;
         end
      end
      if (ch_limit[i] != LIMIT_ENDLESS && int'(ch_count[i]) >= int'(ch_limit[i]))
         ch_step[i] = 8'sd0;
      return moved;
   endfunction

   task automatic predict_levels(input fade_item_type it);
      fade_result_type r;
      fade_result_type tick_out [$];
      int c;
      c = int'(it.channel);
      if (it.kind == KIND_TICK) begin
         for (int i = 0; i < NUM_CH; i++) begin
            if (fade_channel_moves(i) && tick_out.size() < RESULT_CAP) begin
               r.out_channel = 3'(i);
               r.level       = ch_level[i];
               r.matched     = 1'b1;
               r.last        = 1'b0;
               tick_out.push_back(r);
            end
         end
         if (tick_out.size() > 0) begin
            r = tick_out.pop_back();
            r.last = 1'b1;
            tick_out.push_back(r);
         end
         foreach (tick_out[k])
            levels_due.push_back(tick_out[k]);
      end else if (it.kind <= KIND_CLEAR) begin
         r.out_channel = it.channel;
         r.last        = 1'b1;
         if (c >= NUM_CH) begin
            r.level   = 8'd0;
            r.matched = 1'b0;
         end else begin
            case (it.kind)
               KIND_SET: begin
                  ch_level[c] = it.start_level;
                  ch_step[c]  = it.step;
                  ch_lower[c] = it.lower;
                  ch_upper[c] = it.upper;
                  ch_limit[c] = it.loop_limit;
                  ch_count[c] = 8'd0;
               end
               KIND_RESET: begin
                  ch_level[c] = ch_lower[c];
                  ch_count[c] = 8'd0;
               end
               KIND_STOP: begin
                  ch_step[c] = 8'sd0;
               end
               default: begin
                  ch_level[c] = 8'd0;
                  ch_step[c]  = 8'sd0;
                  ch_lower[c] = 8'd0;
                  ch_upper[c] = 8'd0;
                  ch_limit[c] = 8'sd0;
                  ch_count[c] = 8'd0;
               end
            endcase
            r.level   = ch_level[c];
            r.matched = 1'b1;
         end
         // Rows with a typed expectation replace the predicted one.
         if (it.typed) begin
            r.level   = it.typed_level;
            r.matched = it.typed_matched;
         end
         levels_due.push_back(r);
      end
   endtask

   function automatic fade_item_type random_fade_item();
      fade_item_type it;
      int pick;
      it = fade_item(KIND_TICK, 3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom_range(0, 128) - 1),
                     1'b0, 8'd0, 1'b0);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         it.kind = KIND_TICK;
      end else if (pick < 70) begin
         // Well-formed program: start inside the bounds, mostly small steps.
         it.kind        = KIND_SET;
         it.channel     = 3'($urandom_range(0, NUM_CH - 1));
         it.lower       = 8'($urandom_range(0, 200));
         it.upper       = 8'($urandom_range(it.lower, 255));
         it.start_level = 8'($urandom_range(it.lower, it.upper));
         if ($urandom_range(0, 4) != 0)
            it.step = 8'($urandom_range(0, 16) - 8);
         if ($urandom_range(0, 2) == 0)
            it.loop_limit = LIMIT_ENDLESS;
         else if ($urandom_range(0, 9) < 7)
            it.loop_limit = 8'($urandom_range(0, 20));
      end else if (pick < 88) begin
         it.kind    = 3'($urandom_range(KIND_RESET, KIND_CLEAR));
         it.channel = 3'($urandom_range(0, NUM_CH - 1));
      end else begin
         it.kind = 3'($urandom_range(0, 7));
      end
      return it;
   endfunction

   task automatic send_fade_item(input fade_item_type it);
      int gap;
      gap = (items_offered % 64 < 16) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      offered   <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      items_offered++;
      @(negedge clock);
   endtask

   // Check results and predict accepted items.
   always @(posedge clock) begin
      fade_result_type r;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (levels_due.size() == 0) begin
               $display("%0t: unexpected result expected none, got ch %0d level %0d m %0b l %0b",
                        $time, rsp_out_channel, rsp_level, rsp_matched, rsp_last);
               fail_count++;
            end else begin
               r = levels_due.pop_front();
               if (rsp_out_channel !== r.out_channel) begin
                  $display("%0t: out_channel expected %0d, got %0d",
                           $time, r.out_channel, rsp_out_channel);
                  fail_count++;
               end
               if (rsp_level !== r.level) begin
                  $display("%0t: level expected %0d, got %0d", $time, r.level, rsp_level);
                  fail_count++;
               end
               if (rsp_matched !== r.matched) begin
                  $display("%0t: matched expected %0b, got %0b", $time, r.matched, rsp_matched);
                  fail_count++;
               end
               if (rsp_last !== r.last) begin
                  $display("%0t: last expected %0b, got %0b", $time, r.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            predict_levels(offered);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: random stalls, one long hold-off.
   initial begin
      int gap;
      int taken;
      bit held;
      taken = 0;
      held  = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && taken == HOLD_AT) begin
            gap  = HOLD_CYCLES;
            held = 1'b1;
         end else if (taken % 50 < 12) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 19);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         taken++;
         @(negedge clock);
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      fade_item_type it;
      int sent;
      reset     = 1'b1;
      req_valid = 1'b0;
      offered   = fade_item(KIND_TICK, 3'd0, 8'd0, 8'sd0, 8'd0, 8'd0, 8'sd0, 1'b0, 8'd0, 1'b0);
      for (int i = 0; i < NUM_CH; i++) begin
         ch_level[i] = 8'd0;
         ch_step[i]  = 8'sd1;
         ch_lower[i] = 8'd0;
         ch_upper[i] = 8'd0;
         ch_limit[i] = 8'sd0;
         ch_count[i] = 8'd0;
      end

      // Reset state: limit zero stops every channel on the first tick.
      directed_items.push_back(fade_item(KIND_TICK, 3'd6, 8'hFF, -8'sd1, 8'hFF, 8'hFF, -8'sd1,
                                         1'b0, 8'd0, 1'b0));
      directed_items.push_back(fade_item(KIND_RESET, 3'd0, 8'd0, 8'sd0, 8'd0, 8'd0, 8'sd0,
                                         1'b1, 8'd0, 1'b1));
      directed_items.push_back(fade_item(KIND_STOP, 3'd1, 8'd0, 8'sd0, 8'd0, 8'd0, 8'sd0,
                                         1'b1, 8'd0, 1'b1));
      directed_items.push_back(fade_item(KIND_CLEAR, 3'd2, 8'd0, 8'sd0, 8'd0, 8'd0, 8'sd0,
                                         1'b1, 8'd0, 1'b1));
      // Out-of-range channels leave state alone.
      directed_items.push_back(fade_item(KIND_SET, 3'd7, 8'hFF, -8'sd1, 8'hFF, 8'hFF, 8'sd127,
                                         1'b1, 8'd0, 1'b0));
      directed_items.push_back(fade_item(KIND_STOP, 3'd5, 8'd0, 8'sd0, 8'd0, 8'd0, 8'sd0,
                                         1'b1, 8'd0, 1'b0));
      directed_items.push_back(fade_item(KIND_SPARE_LO, 3'd0, 8'd1, 8'sd1, 8'd1, 8'd1, 8'sd1,
                                         1'b0, 8'd0, 1'b0));
      directed_items.push_back(fade_item(KIND_SPARE_HI, 3'd7, 8'hFF, -8'sd1, 8'hFF, 8'hFF,
                                         -8'sd1, 1'b0, 8'd0, 1'b0));
      // Sums past 255 and below 0 must not wrap into range.
      directed_items.push_back(fade_item(KIND_SET, 3'd0, 8'd255, 8'sd127, 8'd0, 8'd255, -8'sd1,
                                         1'b1, 8'd255, 1'b1));
      directed_items.push_back(fade_item(KIND_SET, 3'd1, 8'd0, -8'sd128, 8'd0, 8'd255,
                                         8'sd127, 1'b1, 8'd0, 1'b1));
      directed_items.push_back(fade_item(KIND_SET, 3'd2, 8'd10, 8'sd5, 8'd0, 8'd20, 8'sd2,
                                         1'b1, 8'd10, 1'b1));
      directed_items.push_back(fade_item(KIND_SET, 3'd3, 8'd100, -8'sd1, 8'd0, 8'd255, -8'sd1,
                                         1'b1, 8'd100, 1'b1));
      directed_items.push_back(fade_item(KIND_SET, 3'd4, 8'd0, 8'sd1, 8'd0, 8'd255, 8'sd0,
                                         1'b1, 8'd0, 1'b1));
      repeat (3)
         directed_items.push_back(fade_item(KIND_TICK, 3'd0, 8'd0, 8'sd0, 8'd0, 8'd0, 8'sd0,
                                            1'b0, 8'd0, 1'b0));
      directed_items.push_back(fade_item(KIND_RESET, 3'd2, 8'd0, 8'sd0, 8'd0, 8'd0, 8'sd0,
                                         1'b1, 8'd0, 1'b1));
      directed_items.push_back(fade_item(KIND_STOP, 3'd3, 8'd0, 8'sd0, 8'd0, 8'd0, 8'sd0,
                                         1'b0, 8'd0, 1'b0));
      // All channels endless: a tick reports five updates.
      for (int i = 0; i < NUM_CH; i++)
         directed_items.push_back(fade_item(KIND_SET, 3'(i), 8'(i * 10), 8'sd1, 8'd0, 8'd255,
                                            -8'sd1, 1'b1, 8'(i * 10), 1'b1));
      directed_items.push_back(fade_item(KIND_TICK, 3'd0, 8'd0, 8'sd0, 8'd0, 8'd0, 8'sd0,
                                         1'b0, 8'd0, 1'b0));
      directed_items.push_back(fade_item(KIND_CLEAR, 3'd4, 8'd0, 8'sd0, 8'd0, 8'd0, 8'sd0,
                                         1'b1, 8'd0, 1'b1));
      directed_items.push_back(fade_item(KIND_TICK, 3'd3, 8'd0, 8'sd0, 8'd0, 8'd0, 8'sd0,
                                         1'b0, 8'd0, 1'b0));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_items[k])
         send_fade_item(directed_items[k]);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent == PAUSE_AT) begin
            // Hold off until the block has delivered every pending item.
            req_valid <= 1'b0;
            do @(negedge clock); while (levels_due.size() != 0);
         end
         it = random_fade_item();
         send_fade_item(it);
         sent++;
      end
      req_valid <= 1'b0;

      while (levels_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (levels_due.size() != 0) begin
         $display("%0t: %0d results expected, got none", $time, levels_due.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
